// ===== hw/rtl/fqmtf_pkg.sv =====
// ----------------------------------------------------------------------------
// fqmtf_pkg: shared types and constants for the move-to-front key queue
// Operation and status codes, field widths, controller-to-datapath command.
// ----------------------------------------------------------------------------
package fqmtf_pkg;

  localparam int unsigned DepthDefault    = 16;
  localparam int unsigned KeyWidthDefault = 32;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned KeyIoW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = $clog2(DepthDefault + 1);

  typedef enum logic [FuncW-1:0] {
    FUNC_ENQ = 2'd0,
    FUNC_DEQ = 2'd1,
    FUNC_PRO = 2'd2,
    FUNC_NOP = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch an accepted request
    logic search;   // compare all live entries against the key
    logic commit;   // update storage and load the result register
  } cmd_t;

endpackage

// ===== hw/rtl/fqmtf_req_if.sv =====
// ----------------------------------------------------------------------------
// fqmtf_req_if: request channel
// Valid/ready handshake carrying the operation code and the key.
// ----------------------------------------------------------------------------
interface fqmtf_req_if;
  import fqmtf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FuncW-1:0]         func;
  logic signed [KeyIoW-1:0] key;

  modport source (output valid, output func, output key, input ready);
  modport sink   (input valid, input func, input key, output ready);
endinterface

// ===== hw/rtl/fqmtf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// fqmtf_rsp_if: response channel
// Valid/ready handshake carrying the key out, a status code and the count.
// ----------------------------------------------------------------------------
interface fqmtf_rsp_if #(
  parameter int unsigned CNT_W = fqmtf_pkg::CountW
);
  import fqmtf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [KeyIoW-1:0] key_out;
  logic [StatusW-1:0]       status;
  logic [CNT_W-1:0]         count;

  modport source (output valid, output key_out, output status, output count, input ready);
  modport sink   (input valid, input key_out, input status, input count, output ready);
endinterface

// ===== hw/rtl/fqmtf_ctrl.sv =====
// ----------------------------------------------------------------------------
// fqmtf_ctrl: request sequencer
// Steps each request through a search state and a commit state and owns the
// response valid flag; the commit state may take the next request.
// ----------------------------------------------------------------------------
module fqmtf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output fqmtf_pkg::cmd_t   cmd_o
);
  import fqmtf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_COMMIT = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   commit;
  logic   accept;

  assign out_free    = !out_valid_q || rsp_ready_i;
  assign commit      = (state_q == S_COMMIT) && out_free;
  assign req_ready_o = (state_q == S_IDLE) || commit;
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_SEARCH;
      end
      S_SEARCH: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        // hold until the result register frees up
        if (out_free) state_d = accept ? S_SEARCH : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_valid_o   = out_valid_q;
  assign cmd_o.capture = accept;
  assign cmd_o.search  = (state_q == S_SEARCH);
  assign cmd_o.commit  = commit;

endmodule

// ===== hw/rtl/fqmtf_dp.sv =====
// ----------------------------------------------------------------------------
// fqmtf_dp: key storage and update datapath
// Entry row in head-first order, a parallel compare with first-match
// isolation, and the shift network for enqueue, dequeue and promote.
// ----------------------------------------------------------------------------
module fqmtf_dp #(
  parameter int unsigned DEPTH     = fqmtf_pkg::DepthDefault,
  parameter int unsigned KEY_WIDTH = fqmtf_pkg::KeyWidthDefault,
  parameter int unsigned CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fqmtf_pkg::cmd_t                 cmd_i,
  input  logic [fqmtf_pkg::FuncW-1:0]     req_func_i,
  input  logic [fqmtf_pkg::KeyIoW-1:0]    req_key_i,
  output logic [fqmtf_pkg::KeyIoW-1:0]    rsp_key_out_o,
  output logic [fqmtf_pkg::StatusW-1:0]   rsp_status_o,
  output logic [CNT_W-1:0]                rsp_count_o
);
  import fqmtf_pkg::*;

  logic [KEY_WIDTH-1:0] entries_q [DEPTH];
  logic [KEY_WIDTH-1:0] entries_d [DEPTH];
  logic [CNT_W-1:0]     count_q, count_d;
  func_e                func_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [DEPTH-1:0]     match;
  logic [DEPTH-1:0]     first_q;
  logic                 found_q;
  logic [DEPTH-1:0]     shift_mask;
  logic [KeyIoW-1:0]    key_out_q, key_out_d;
  status_e              status_q, status_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_e'(req_func_i);
      key_q  <= KEY_WIDTH'(req_key_i);
    end
  end

  // Compare every live entry; keep only the match nearest the head
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = (CNT_W'(i) < count_q) && (entries_q[i] == key_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.search) begin
      first_q <= match & (~match + DEPTH'(1));
      found_q <= |match;
    end
  end

  // Positions from the head through the match move down by one
  assign shift_mask = first_q | (first_q - DEPTH'(1));

  always_comb begin
    entries_d = entries_q;
    count_d   = count_q;
    status_d  = STAT_OK;
    key_out_d = '0;
    if (cmd_i.commit) begin
      unique case (func_q)
        FUNC_ENQ: begin
          if (count_q == CNT_W'(DEPTH)) begin
            status_d = STAT_FULL;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              if (CNT_W'(i) == count_q) entries_d[i] = key_q;
            end
            count_d = count_q + CNT_W'(1);
          end
        end
        FUNC_DEQ: begin
          if (count_q == '0) begin
            status_d = STAT_EMPTY;
          end else begin
            key_out_d = KeyIoW'(entries_q[0]);
            for (int i = 0; i < DEPTH - 1; i++) begin
              entries_d[i] = entries_q[i+1];
            end
            count_d = count_q - CNT_W'(1);
          end
        end
        FUNC_PRO: begin
          if (count_q == '0) begin
            status_d = STAT_EMPTY;
          end else if (!found_q) begin
            status_d = STAT_NOTFOUND;
          end else begin
            // matched entry equals the key, so write the key at the head
            entries_d[0] = key_q;
            for (int i = 1; i < DEPTH; i++) begin
              if (shift_mask[i]) entries_d[i] = entries_q[i-1];
            end
          end
        end
        FUNC_NOP: begin
          status_d = STAT_OK;
        end
        default: status_d = STAT_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    entries_q <= entries_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      key_out_q <= key_out_d;
      status_q  <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // count only moves on commit, and commit waits for the result to drain
  assign rsp_key_out_o = key_out_q;
  assign rsp_status_o  = status_q;
  assign rsp_count_o   = count_q;

endmodule

// ===== hw/rtl/fifo_queue_with_move_to_front_unit.sv =====
// ----------------------------------------------------------------------------
// fifo_queue_with_move_to_front_unit: bounded key queue with promote
// Enqueue at the tail, dequeue from the head, or move the first matching
// key to the head; one response per request.
//
//   channel | dir | payload                    | handshake
//   req_i   | in  | func, key                  | valid / ready
//   rsp_o   | out | key_out, status, count     | valid / ready
//
// Each request passes through a search state (all live entries compared in
// parallel, first match isolated) and a commit state (storage shift, result
// register load). The next request is accepted in the commit cycle.
// Commit stalls while a previous response sits unaccepted in the result
// register. Reset clears the sequencer state, the response valid flag and the
// entry count; entries are not cleared.
// ----------------------------------------------------------------------------
module fifo_queue_with_move_to_front_unit #(
  parameter int unsigned DEPTH     = fqmtf_pkg::DepthDefault,
  parameter int unsigned KEY_WIDTH = fqmtf_pkg::KeyWidthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  fqmtf_req_if.sink    req_i,
  fqmtf_rsp_if.source  rsp_o
);
  import fqmtf_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t              cmd;
  logic [KeyIoW-1:0] key_out;
  logic [StatusW-1:0] status;
  logic [CNT_W-1:0]  count;

  fqmtf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  fqmtf_dp #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH),
    .CNT_W     (CNT_W)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .req_func_i    (req_i.func),
    .req_key_i     (req_i.key),
    .rsp_key_out_o (key_out),
    .rsp_status_o  (status),
    .rsp_count_o   (count)
  );

  assign rsp_o.key_out = key_out;
  assign rsp_o.status  = status;
  assign rsp_o.count   = count;

endmodule

// ===== hw/rtl/fqmtf_chk.sv =====
// ----------------------------------------------------------------------------
// fqmtf_chk: port-level checks for the move-to-front key queue
// Watches both channels and is bound to the top level.
// ----------------------------------------------------------------------------
module fqmtf_chk #(
  parameter int unsigned DEPTH = fqmtf_pkg::DepthDefault,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  input  logic                          req_ready_i,
  input  logic                          rsp_valid_i,
  input  logic                          rsp_ready_i,
  input  logic [fqmtf_pkg::KeyIoW-1:0]  rsp_key_out_i,
  input  logic [fqmtf_pkg::StatusW-1:0] rsp_status_i,
  input  logic [CNT_W-1:0]              rsp_count_i
);
  import fqmtf_pkg::*;

  logic [CNT_W-1:0] last_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_count_q <= '0;
    end else if (rsp_valid_i && rsp_ready_i) begin
      last_count_q <= rsp_count_i;
    end
  end

  // a response stays up until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped before it was taken");

  // one request in flight: no request taken in the cycle after one is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted during search");

  // each request moves the count by at most one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_count_i == last_count_q) ||
                    (rsp_count_i == last_count_q + CNT_W'(1)) ||
                    (rsp_count_i + CNT_W'(1) == last_count_q))
    else $error("count jumped by more than one");

  // empty and full reports agree with the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_status_i != STAT_EMPTY || rsp_count_i == '0) &&
                    (rsp_status_i != STAT_FULL || rsp_count_i == CNT_W'(DEPTH)))
    else $error("status disagrees with count");

  // a key comes out only on a successful response
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_key_out_i != '0 |-> rsp_status_i == STAT_OK)
    else $error("key out on an error response");

endmodule

bind fifo_queue_with_move_to_front_unit fqmtf_chk #(
  .DEPTH (DEPTH),
  .CNT_W (CNT_W)
) u_fqmtf_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_key_out_i (rsp_o.key_out),
  .rsp_status_i  (rsp_o.status),
  .rsp_count_i   (rsp_o.count)
);

// ===== dv/tb_fifo_queue_with_move_to_front_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fifo_queue_with_move_to_front_unit: self-checking bench for the key queue
// Walks a directed table (empty and full edges, extreme keys, duplicates,
// head and missing keys on promote, the unused opcode), then sends random
// fill/drain traffic. Every response is checked field by field against the
// row's result or a queue-based prediction, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_fifo_queue_with_move_to_front_unit;
  import fqmtf_pkg::*;

  localparam int unsigned QueueDepth = DepthDefault;
  localparam int          RandomOps  = 400;
  localparam int          IdleLimit  = 1000;
  localparam int          NumRows    = 25;

  typedef struct {
    logic [KeyIoW-1:0] key_out;
    status_e           status;
    logic [CountW-1:0] count;
  } queue_result_t;

  typedef struct {
    func_e             op;
    logic [KeyIoW-1:0] key;
    bit                typed;
    queue_result_t     res;
  } stim_row_t;

  // Directed rows; typed rows carry their result, the rest use the prediction.
  stim_row_t directed_rows [NumRows] = '{
    '{FUNC_DEQ, 32'h0000_0000, 1'b1, '{32'h0, STAT_EMPTY, 5'd0}},
    '{FUNC_PRO, 32'h0000_0005, 1'b1, '{32'h0, STAT_EMPTY, 5'd0}},
    '{FUNC_NOP, 32'hFFFF_FFFF, 1'b1, '{32'h0, STAT_OK, 5'd0}},
    '{FUNC_ENQ, 32'h7FFF_FFFF, 1'b1, '{32'h0, STAT_OK, 5'd1}},
    '{FUNC_ENQ, 32'h8000_0000, 1'b1, '{32'h0, STAT_OK, 5'd2}},
    '{FUNC_ENQ, 32'hFFFF_FFFF, 1'b1, '{32'h0, STAT_OK, 5'd3}},
    '{FUNC_ENQ, 32'h8000_0000, 1'b1, '{32'h0, STAT_OK, 5'd4}},
    '{FUNC_ENQ, 32'h0000_0000, 1'b1, '{32'h0, STAT_OK, 5'd5}},
    '{FUNC_ENQ, 32'h0000_0001, 1'b1, '{32'h0, STAT_OK, 5'd6}},
    '{FUNC_ENQ, 32'h5555_5555, 1'b1, '{32'h0, STAT_OK, 5'd7}},
    '{FUNC_ENQ, 32'hAAAA_AAAA, 1'b1, '{32'h0, STAT_OK, 5'd8}},
    '{FUNC_ENQ, 32'h1234_5678, 1'b1, '{32'h0, STAT_OK, 5'd9}},
    '{FUNC_ENQ, 32'h0000_FFFF, 1'b1, '{32'h0, STAT_OK, 5'd10}},
    '{FUNC_ENQ, 32'hFFFF_0000, 1'b1, '{32'h0, STAT_OK, 5'd11}},
    '{FUNC_ENQ, 32'h0F0F_0F0F, 1'b1, '{32'h0, STAT_OK, 5'd12}},
    '{FUNC_ENQ, 32'hF0F0_F0F0, 1'b1, '{32'h0, STAT_OK, 5'd13}},
    '{FUNC_ENQ, 32'h3333_3333, 1'b1, '{32'h0, STAT_OK, 5'd14}},
    '{FUNC_ENQ, 32'hCCCC_CCCC, 1'b1, '{32'h0, STAT_OK, 5'd15}},
    '{FUNC_ENQ, 32'hDEAD_BEEF, 1'b1, '{32'h0, STAT_OK, 5'd16}},
    '{FUNC_ENQ, 32'h0000_0003, 1'b1, '{32'h0, STAT_FULL, 5'd16}},
    '{FUNC_PRO, 32'h7FFF_FFFF, 1'b1, '{32'h0, STAT_OK, 5'd16}},
    '{FUNC_PRO, 32'h8000_0000, 1'b0, '{32'h0, STAT_OK, 5'd0}},
    '{FUNC_PRO, 32'h0000_9999, 1'b1, '{32'h0, STAT_NOTFOUND, 5'd16}},
    '{FUNC_PRO, 32'hDEAD_BEEF, 1'b0, '{32'h0, STAT_OK, 5'd0}},
    '{FUNC_DEQ, 32'h0000_0000, 1'b0, '{32'h0, STAT_OK, 5'd0}}
  };

  logic clk_i;
  logic rst_ni;

  fqmtf_req_if req_ch ();
  fqmtf_rsp_if rsp_ch ();

  fifo_queue_with_move_to_front_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  logic [KeyIoW-1:0] model_keys [$];
  queue_result_t     results_due [$];
  int                error_count = 0;
  bit                send_burst = 1'b0;
  bit                recv_burst = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Apply one operation to the modeled queue and return its response.
  function automatic queue_result_t apply_queue_op(func_e op, logic [KeyIoW-1:0] key);
    queue_result_t     r;
    int                hit;
    logic [KeyIoW-1:0] moved;
    r.key_out = '0;
    r.status  = STAT_OK;
    hit       = -1;
    case (op)
      FUNC_ENQ: begin
        if (model_keys.size() >= QueueDepth) r.status = STAT_FULL;
        else model_keys.push_back(key);
      end
      FUNC_DEQ: begin
        if (model_keys.size() == 0) r.status = STAT_EMPTY;
        else r.key_out = model_keys.pop_front();
      end
      FUNC_PRO: begin
        if (model_keys.size() == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          for (int i = 0; i < model_keys.size(); i++) begin
            if (hit < 0 && model_keys[i] == key) hit = i;
          end
          if (hit < 0) begin
            r.status = STAT_NOTFOUND;
          end else if (hit > 0) begin
            moved = model_keys[hit];
            model_keys.delete(hit);
            model_keys.push_front(moved);
          end
        end
      end
      default: ;
    endcase
    r.count = CountW'(model_keys.size());
    return r;
  endfunction

  function automatic logic [KeyIoW-1:0] draw_key();
    logic [KeyIoW-1:0] pool [8] = '{32'h0, 32'h1, 32'h2, 32'h3, 32'hFFFF_FFFF,
                                    32'h8000_0000, 32'h7FFF_FFFF, 32'h5};
    if ($urandom_range(0, 2) == 0) return $urandom();
    return pool[$urandom_range(0, 7)];
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue_request(input func_e op, input logic [KeyIoW-1:0] key,
                               input bit use_typed, input queue_result_t typed_res);
    int            gap;
    queue_result_t r;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.func  <= op;
    req_ch.key   <= key;
    do @(posedge clk_i); while (!req_ch.ready);
    r = apply_queue_op(op, key);
    results_due.push_back(use_typed ? typed_res : r);
    @(negedge clk_i);
  endtask

  // Response side: random back-pressure, compare each response in order.
  initial begin
    int            stall;
    queue_result_t want;
    rsp_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_ch.valid);
      if (results_due.size() == 0) begin
        $error("unexpected response: key_out %h status %0d count %0d",
               rsp_ch.key_out, rsp_ch.status, rsp_ch.count);
        error_count++;
      end else begin
        want = results_due.pop_front();
        if (rsp_ch.key_out !== want.key_out) begin
          $error("key_out: expected %h, got %h", want.key_out, rsp_ch.key_out);
          error_count++;
        end
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          error_count++;
        end
        if (rsp_ch.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, rsp_ch.count);
          error_count++;
        end
      end
      @(negedge clk_i);
    end
  end

  // Abort when neither channel moves for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    bit                filling;
    int                pick;
    func_e             op;
    logic [KeyIoW-1:0] key;
    queue_result_t     unused_res;
    req_ch.valid = 1'b0;
    req_ch.func  = FUNC_ENQ;
    req_ch.key   = '0;
    rst_ni       = 1'b0;
    unused_res   = '{32'h0, STAT_OK, 5'd0};
    filling      = 1'b1;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      issue_request(directed_rows[i].op, directed_rows[i].key,
                    directed_rows[i].typed, directed_rows[i].res);
    end

    // Hold until the block has drained every outstanding response.
    req_ch.valid <= 1'b0;
    wait (results_due.size() == 0);
    @(negedge clk_i);

    for (int n = 0; n < RandomOps; n++) begin
      if (model_keys.size() == QueueDepth) filling = 1'b0;
      else if (model_keys.size() == 0) filling = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < (filling ? 55 : 15)) op = FUNC_ENQ;
      else if (pick < (filling ? 70 : 55)) op = FUNC_DEQ;
      else if (pick < 97) op = FUNC_PRO;
      else op = FUNC_NOP;
      // Promote mostly hits a live key; otherwise a pooled or random key.
      if (op == FUNC_PRO && model_keys.size() > 0 && $urandom_range(0, 9) < 7)
        key = model_keys[$urandom_range(0, model_keys.size() - 1)];
      else
        key = draw_key();
      issue_request(op, key, 1'b0, unused_res);
    end
    req_ch.valid <= 1'b0;

    wait (results_due.size() == 0);
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/fqmtf_pkg.sv
hw/rtl/fqmtf_req_if.sv
hw/rtl/fqmtf_rsp_if.sv
hw/rtl/fqmtf_ctrl.sv
hw/rtl/fqmtf_dp.sv
hw/rtl/fifo_queue_with_move_to_front_unit.sv
hw/rtl/fqmtf_chk.sv
dv/tb_fifo_queue_with_move_to_front_unit.sv
